>>> design/tpa_pkg.sv
`default_nettype none
package tpa_pkg;

	localparam int SQRT_STEPS = 32;
	localparam int SQ_W       = 64;
	localparam int ROOT_W     = 32;
	localparam int SIDE_W     = 30;
	localparam int PERIM_W    = 19;
	localparam int AREA_W     = 24;
	localparam int OUT_W      = 48;
	localparam int HERON_SHIFT = 20;

	localparam logic [SIDE_W-1:0]  SIDE_CAP  = {SIDE_W{1'b1}};
	localparam logic [PERIM_W-1:0] PERIM_MAX = {PERIM_W{1'b1}};
	localparam logic [AREA_W-1:0]  AREA_MAX  = {AREA_W{1'b1}};

endpackage
`default_nettype wire

>>> design/tpa_sqrt_cell.sv
`default_nettype none
module tpa_sqrt_cell import tpa_pkg::*; #(
	parameter int LANES = 1,
	parameter int PW    = 1,
	parameter int STEP  = 0
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              v_i,
	output      logic              rdy_o,
	input  wire logic [SQ_W-1:0]   n_i [LANES],
	input  wire logic [SQ_W-1:0]   r_i [LANES],
	input  wire logic [PW-1:0]     pay_i,
	output      logic              v_o,
	input  wire logic              rdy_i,
	output      logic [SQ_W-1:0]   n_o [LANES],
	output      logic [SQ_W-1:0]   r_o [LANES],
	output      logic [PW-1:0]     pay_o
);

	// One step of the restoring square root: this cell tries one result bit.
	localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * STEP);

	logic            v_q;
	logic [SQ_W-1:0] n_q [LANES];
	logic [SQ_W-1:0] r_q [LANES];
	logic [PW-1:0]   pay_q;
	logic [SQ_W-1:0] n_nxt [LANES];
	logic [SQ_W-1:0] r_nxt [LANES];

	assign rdy_o = !v_q || rdy_i;

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			if (n_i[l] >= r_i[l] + BIT) begin
				n_nxt[l] = n_i[l] - (r_i[l] + BIT);
				r_nxt[l] = (r_i[l] >> 1) + BIT;
			end else begin
				n_nxt[l] = n_i[l];
				r_nxt[l] = r_i[l] >> 1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (rdy_o) begin
			v_q <= v_i;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_o && v_i) begin
			n_q   <= n_nxt;
			r_q   <= r_nxt;
			pay_q <= pay_i;
		end
	end

	assign v_o   = v_q;
	assign n_o   = n_q;
	assign r_o   = r_q;
	assign pay_o = pay_q;

endmodule
`default_nettype wire

>>> design/tpa_sqrt_chain.sv
`default_nettype none
module tpa_sqrt_chain import tpa_pkg::*; #(
	parameter int LANES = 1,
	parameter int PW    = 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              v_i,
	output      logic              rdy_o,
	input  wire logic [SQ_W-1:0]   n_i [LANES],
	input  wire logic [PW-1:0]     pay_i,
	output      logic              v_o,
	input  wire logic              rdy_i,
	output      logic [ROOT_W-1:0] root_o [LANES],
	output      logic [PW-1:0]     pay_o
);

	logic            v_w   [SQRT_STEPS+1];
	logic            rdy_w [SQRT_STEPS+1];
	logic [SQ_W-1:0] n_w   [SQRT_STEPS+1][LANES];
	logic [SQ_W-1:0] r_w   [SQRT_STEPS+1][LANES];
	logic [PW-1:0]   pay_w [SQRT_STEPS+1];

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			n_w[0][l] = n_i[l];
			r_w[0][l] = '0;
		end
	end

	assign v_w[0]   = v_i;
	assign pay_w[0] = pay_i;
	assign rdy_o    = rdy_w[0];

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_cell
		tpa_sqrt_cell #(.LANES(LANES), .PW(PW), .STEP(k)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.v_i    (v_w[k]),
			.rdy_o  (rdy_w[k]),
			.n_i    (n_w[k]),
			.r_i    (r_w[k]),
			.pay_i  (pay_w[k]),
			.v_o    (v_w[k+1]),
			.rdy_i  (rdy_w[k+1]),
			.n_o    (n_w[k+1]),
			.r_o    (r_w[k+1]),
			.pay_o  (pay_w[k+1])
		);
	end

	assign rdy_w[SQRT_STEPS] = rdy_i;
	assign v_o   = v_w[SQRT_STEPS];
	assign pay_o = pay_w[SQRT_STEPS];

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			root_o[l] = r_w[SQRT_STEPS][l][ROOT_W-1:0];
		end
	end

endmodule
`default_nettype wire

>>> design/tpa_side_front.sv
`default_nettype none
module tpa_side_front import tpa_pkg::*; #(
	parameter int COORD_WIDTH = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   v_i,
	output      logic                   rdy_o,
	input  wire logic [COORD_WIDTH-1:0] ax,
	input  wire logic [COORD_WIDTH-1:0] ay,
	input  wire logic [COORD_WIDTH-1:0] bx,
	input  wire logic [COORD_WIDTH-1:0] by_coord,
	input  wire logic [COORD_WIDTH-1:0] cx,
	input  wire logic [COORD_WIDTH-1:0] cy,
	output      logic                   v_o,
	input  wire logic                   rdy_i,
	output      logic [SQ_W-1:0]        sq_o [3]
);

	localparam int D_W   = COORD_WIDTH + 1;
	localparam int SUM_W = 2 * D_W + 1;

	// Lanes: 0 is side AB, 1 is side BC, 2 is side AC.
	logic [COORD_WIDTH-1:0] p_x [3];
	logic [COORD_WIDTH-1:0] p_y [3];
	logic [COORD_WIDTH-1:0] q_x [3];
	logic [COORD_WIDTH-1:0] q_y [3];
	logic signed [D_W-1:0]  dx_sgn [3];
	logic signed [D_W-1:0]  dy_sgn [3];
	logic [D_W-1:0]         dx_abs [3];
	logic [D_W-1:0]         dy_abs [3];
	logic [SUM_W-1:0]       sum_w  [3];
	logic [SUM_W+SQ_W-1:0]  sum_ext [3];
	logic [SQ_W-1:0]        sq_sat [3];

	logic           v_s1, v_s2;
	logic           rdy_s1, rdy_s2;
	logic [D_W-1:0] dx_s1 [3];
	logic [D_W-1:0] dy_s1 [3];
	logic [SQ_W-1:0] sq_s2 [3];

	assign p_x = '{ax, bx, ax};
	assign p_y = '{ay, by_coord, ay};
	assign q_x = '{bx, cx, cx};
	assign q_y = '{by_coord, cy, cy};

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			dx_sgn[l] = $signed({p_x[l][COORD_WIDTH-1], p_x[l]})
				- $signed({q_x[l][COORD_WIDTH-1], q_x[l]});
			dy_sgn[l] = $signed({p_y[l][COORD_WIDTH-1], p_y[l]})
				- $signed({q_y[l][COORD_WIDTH-1], q_y[l]});
			dx_abs[l] = dx_sgn[l][D_W-1] ? D_W'(-dx_sgn[l]) : D_W'(dx_sgn[l]);
			dy_abs[l] = dy_sgn[l][D_W-1] ? D_W'(-dy_sgn[l]) : D_W'(dy_sgn[l]);
		end
	end

	// A sum of squares beyond 64 bits saturates to all ones.
	always_comb begin
		for (int l = 0; l < 3; l++) begin
			sum_w[l]   = SUM_W'(dx_s1[l] * dx_s1[l]) + SUM_W'(dy_s1[l] * dy_s1[l]);
			sum_ext[l] = {{SQ_W{1'b0}}, sum_w[l]};
			sq_sat[l]  = (|sum_ext[l][SUM_W+SQ_W-1:SQ_W]) ? {SQ_W{1'b1}}
				: sum_ext[l][SQ_W-1:0];
		end
	end

	assign rdy_s2 = !v_s2 || rdy_i;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign rdy_o  = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= v_i;
			if (rdy_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && v_i) begin
			dx_s1 <= dx_abs;
			dy_s1 <= dy_abs;
		end
		if (rdy_s2 && v_s1) begin
			sq_s2 <= sq_sat;
		end
	end

	assign v_o  = v_s2;
	assign sq_o = sq_s2;

endmodule
`default_nettype wire

>>> design/tpa_heron_prod.sv
`default_nettype none
module tpa_heron_prod import tpa_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               v_i,
	output      logic               rdy_o,
	input  wire logic [ROOT_W-1:0]  side_i [3],
	output      logic               v_o,
	input  wire logic               rdy_i,
	output      logic [SQ_W-1:0]    q_o,
	output      logic [PERIM_W-1:0] perim_o
);

	localparam int H = ROOT_W;

	logic [ROOT_W+1:0]  psum;
	logic [PERIM_W-1:0] perim_nxt;
	logic [SIDE_W-1:0]  cap [3];
	logic [ROOT_W-1:0]  pcap;
	logic               ok_nxt;
	logic [ROOT_W-1:0]  d_nxt [3];
	logic [2*SQ_W-1:0]  full;
	logic [SQ_W-1:0]    q_nxt;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5;

	logic [SIDE_W-1:0]  side_s1 [3];
	logic [ROOT_W-1:0]  p_s1;
	logic [PERIM_W-1:0] perim_s1, perim_s2, perim_s3, perim_s4, perim_s5;
	logic               ok_s2, ok_s3, ok_s4;
	logic [ROOT_W-1:0]  p_s2;
	logic [ROOT_W-1:0]  d_s2 [3];
	logic [SQ_W-1:0]    x_s3, y_s3;
	logic [SQ_W-1:0]    pp_s4 [4];
	logic [SQ_W-1:0]    q_s5;

	always_comb begin
		psum = (ROOT_W+2)'(side_i[0]) + (ROOT_W+2)'(side_i[1]) + (ROOT_W+2)'(side_i[2]);
		perim_nxt = (psum > (ROOT_W+2)'(PERIM_MAX)) ? PERIM_MAX : psum[PERIM_W-1:0];
		for (int l = 0; l < 3; l++) begin
			cap[l] = (side_i[l] > ROOT_W'(SIDE_CAP)) ? SIDE_CAP : side_i[l][SIDE_W-1:0];
		end
		pcap = ROOT_W'(cap[0]) + ROOT_W'(cap[1]) + ROOT_W'(cap[2]);
	end

	// The triangle is valid for Heron only if no factor would go negative.
	always_comb begin
		ok_nxt = 1'b1;
		for (int l = 0; l < 3; l++) begin
			if (p_s1 < {1'b0, side_s1[l], 1'b0}) ok_nxt = 1'b0;
			d_nxt[l] = p_s1 - {1'b0, side_s1[l], 1'b0};
		end
	end

	always_comb begin
		full = {{SQ_W{1'b0}}, pp_s4[0]}
			+ {{H{1'b0}}, pp_s4[1], {H{1'b0}}}
			+ {{H{1'b0}}, pp_s4[2], {H{1'b0}}}
			+ {pp_s4[3], {SQ_W{1'b0}}};
		if (!ok_s4) begin
			q_nxt = '0;
		end else if (|full[2*SQ_W-1:SQ_W+HERON_SHIFT]) begin
			q_nxt = {SQ_W{1'b1}};
		end else begin
			q_nxt = full[SQ_W+HERON_SHIFT-1:HERON_SHIFT];
		end
	end

	assign rdy_s5 = !v_s5 || rdy_i;
	assign rdy_s4 = !v_s4 || rdy_s5;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign rdy_o  = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= v_i;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && v_i) begin
			side_s1  <= cap;
			p_s1     <= pcap;
			perim_s1 <= perim_nxt;
		end
		if (rdy_s2 && v_s1) begin
			ok_s2    <= ok_nxt;
			p_s2     <= p_s1;
			d_s2     <= d_nxt;
			perim_s2 <= perim_s1;
		end
		if (rdy_s3 && v_s2) begin
			x_s3     <= SQ_W'(p_s2 * d_s2[0]);
			y_s3     <= SQ_W'(d_s2[1] * d_s2[2]);
			ok_s3    <= ok_s2;
			perim_s3 <= perim_s2;
		end
		if (rdy_s4 && v_s3) begin
			pp_s4[0] <= SQ_W'(x_s3[H-1:0] * y_s3[H-1:0]);
			pp_s4[1] <= SQ_W'(x_s3[H-1:0] * y_s3[SQ_W-1:H]);
			pp_s4[2] <= SQ_W'(x_s3[SQ_W-1:H] * y_s3[H-1:0]);
			pp_s4[3] <= SQ_W'(x_s3[SQ_W-1:H] * y_s3[SQ_W-1:H]);
			ok_s4    <= ok_s3;
			perim_s4 <= perim_s3;
		end
		if (rdy_s5 && v_s4) begin
			q_s5     <= q_nxt;
			perim_s5 <= perim_s4;
		end
	end

	assign v_o     = v_s5;
	assign q_o     = q_s5;
	assign perim_o = perim_s5;

endmodule
`default_nettype wire

>>> design/triangle_perimeter_area_unit.sv
// Triangle perimeter and Heron area unit.
// Slave channel s_*: one request per triangle, six signed coordinates with
// eight fraction bits, packed in s_tdata as ax, ay, bx, by_coord, cx, cy.
// Master channel m_*: one result per request, perimeter and area, both
// unsigned with eight fraction bits, in request order.
// From acceptance to m_tvalid a request passes the difference and squaring
// registers, 32 square-root cells for the three sides, the Heron product
// registers, 32 square-root cells for the area and one output register.
// Throughput is one request per cycle while not stalled; each stage is a
// register with its own valid bit, so a stalled receiver only stops full
// stages, and empty stages behind a waiting result still take new requests.
// Reset clears all valid bits; the pipeline then holds no request.
// The ready path runs combinationally back through the whole cell chain.
`default_nettype none
module triangle_perimeter_area_unit import tpa_pkg::*; #(
	parameter int COORD_WIDTH = 16
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 s_tvalid,
	output      logic                                 s_tready,
	// ax, ay, bx, by_coord, cx, cy from bit 0 up, zero padded to bytes
	input  wire logic [((6*COORD_WIDTH+7)/8)*8-1:0]   s_tdata,
	output      logic                                 m_tvalid,
	input  wire logic                                 m_tready,
	// perimeter [18:0], area [42:19], zero padded to bytes
	output      logic [OUT_W-1:0]                     m_tdata
);

	localparam int W = COORD_WIDTH;

	logic            fr_v, fr_rdy;
	logic [SQ_W-1:0] fr_sq [3];

	logic              sd_v, sd_rdy;
	logic [ROOT_W-1:0] sd_root [3];
	logic [0:0]        sd_pay;

	logic               hp_v, hp_rdy;
	logic [SQ_W-1:0]    hp_q [1];
	logic [PERIM_W-1:0] hp_perim;

	logic               ar_v, ar_rdy;
	logic [ROOT_W-1:0]  ar_root [1];
	logic [PERIM_W-1:0] ar_perim;
	logic [AREA_W-1:0]  area_nxt;

	logic               out_v_q;
	logic [PERIM_W-1:0] perimeter_q;
	logic [AREA_W-1:0]  area_q;

	tpa_side_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.v_i      (s_tvalid),
		.rdy_o    (s_tready),
		.ax       (s_tdata[W-1:0]),
		.ay       (s_tdata[2*W-1:W]),
		.bx       (s_tdata[3*W-1:2*W]),
		.by_coord (s_tdata[4*W-1:3*W]),
		.cx       (s_tdata[5*W-1:4*W]),
		.cy       (s_tdata[6*W-1:5*W]),
		.v_o      (fr_v),
		.rdy_i    (fr_rdy),
		.sq_o     (fr_sq)
	);

	tpa_sqrt_chain #(.LANES(3), .PW(1)) u_side_root (
		.clk    (clk),
		.arst_n (arst_n),
		.v_i    (fr_v),
		.rdy_o  (fr_rdy),
		.n_i    (fr_sq),
		.pay_i  (1'b0),
		.v_o    (sd_v),
		.rdy_i  (sd_rdy),
		.root_o (sd_root),
		.pay_o  (sd_pay)
	);

	tpa_heron_prod u_heron (
		.clk     (clk),
		.arst_n  (arst_n),
		.v_i     (sd_v),
		.rdy_o   (sd_rdy),
		.side_i  (sd_root),
		.v_o     (hp_v),
		.rdy_i   (hp_rdy),
		.q_o     (hp_q[0]),
		.perim_o (hp_perim)
	);

	tpa_sqrt_chain #(.LANES(1), .PW(PERIM_W)) u_area_root (
		.clk    (clk),
		.arst_n (arst_n),
		.v_i    (hp_v),
		.rdy_o  (hp_rdy),
		.n_i    (hp_q),
		.pay_i  (hp_perim),
		.v_o    (ar_v),
		.rdy_i  (ar_rdy),
		.root_o (ar_root),
		.pay_o  (ar_perim)
	);

	assign area_nxt = (ar_root[0] > ROOT_W'(AREA_MAX)) ? AREA_MAX
		: ar_root[0][AREA_W-1:0];
	assign ar_rdy = !out_v_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (ar_rdy) begin
			out_v_q <= ar_v;
		end
	end

	always_ff @(posedge clk) begin
		if (ar_rdy && ar_v) begin
			perimeter_q <= ar_perim;
			area_q      <= area_nxt;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {(OUT_W-PERIM_W-AREA_W)'(0), area_q, perimeter_q};

`ifndef SYNTHESIS
	// A positive area needs a positive perimeter.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && (area_q != '0) |-> (perimeter_q != '0))
		else $error("area without perimeter");

	// A triangle shorter than one unit around has an area below one unit.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && (perimeter_q[PERIM_W-1:8] == '0) |-> (area_q[AREA_W-1:8] == '0))
		else $error("area too large for perimeter");

	// The dummy side payload never travels as anything but zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		sd_v |-> (sd_pay == 1'b0))
		else $error("side payload corrupted");
`endif

endmodule
`default_nettype wire

>>> test/triangle_perimeter_area_unit_tb.sv
`timescale 1ns / 1ps
module triangle_perimeter_area_unit_tb;
	import tpa_pkg::*;

	localparam int CW = 16;
	localparam int IN_W = ((6*CW+7)/8)*8;
	localparam int LATENCY = 72;
	localparam int STALL_LIMIT = 20000;
	localparam int N_RANDOM = 1400;

	typedef struct packed {
		logic [PERIM_W-1:0] perim;
		logic [AREA_W-1:0]  area;
	} tri_result_t;

	typedef struct {
		logic [CW-1:0] c[6];
		bit            known;
		tri_result_t   res;
	} tri_row_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [IN_W-1:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [OUT_W-1:0] m_tdata;

	tri_result_t expected_q[$];
	tri_row_t    rows[$];
	int errors;
	int quiet_cycles;
	bit rx_hold;
	bit no_idle;
	bit sending;

	triangle_perimeter_area_unit #(.COORD_WIDTH(CW)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	function automatic logic [63:0] int_sqrt(logic [63:0] n);
		logic [63:0] r;
		logic [63:0] b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n)
			b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic logic [63:0] edge_len(logic signed [CW-1:0] x1, logic signed [CW-1:0] y1,
			logic signed [CW-1:0] x2, logic signed [CW-1:0] y2);
		longint dx;
		longint dy;
		logic [64:0] s;
		dx = longint'(x1) - longint'(x2);
		dy = longint'(y1) - longint'(y2);
		if (dx < 0) dx = -dx;
		if (dy < 0) dy = -dy;
		s = 65'(dx * dx) + 65'(dy * dy);
		if (s[64]) s = {1'b0, {64{1'b1}}};
		return int_sqrt(s[63:0]);
	endfunction

	function automatic tri_result_t triangle_metrics(logic [CW-1:0] c[6]);
		logic [63:0] ab, bc, ac, p, tot, a, b, cc, x, y;
		logic [127:0] prod;
		logic [63:0] q, ar;
		tri_result_t r;
		ab = edge_len(c[0], c[1], c[2], c[3]);
		bc = edge_len(c[2], c[3], c[4], c[5]);
		ac = edge_len(c[0], c[1], c[4], c[5]);
		tot = ab + bc + ac;
		r.perim = (tot > 64'(PERIM_MAX)) ? PERIM_MAX : tot[PERIM_W-1:0];
		a = (ab > 64'(SIDE_CAP)) ? 64'(SIDE_CAP) : ab;
		b = (bc > 64'(SIDE_CAP)) ? 64'(SIDE_CAP) : bc;
		cc = (ac > 64'(SIDE_CAP)) ? 64'(SIDE_CAP) : ac;
		p = a + b + cc;
		r.area = '0;
		if (p >= 2*a && p >= 2*b && p >= 2*cc) begin
			x = p * (p - 2*a);
			y = (p - 2*b) * (p - 2*cc);
			prod = 128'(x) * 128'(y);
			q = (prod[127:84] != 0) ? {64{1'b1}} : prod[83:20];
			ar = int_sqrt(q);
			r.area = (ar > 64'(AREA_MAX)) ? AREA_MAX : ar[AREA_W-1:0];
		end
		return r;
	endfunction

	task automatic add_row(int v0, int v1, int v2, int v3, int v4, int v5,
			bit known = 0, int perim = 0, int area = 0);
		tri_row_t row;
		row.c[0] = v0[CW-1:0];
		row.c[1] = v1[CW-1:0];
		row.c[2] = v2[CW-1:0];
		row.c[3] = v3[CW-1:0];
		row.c[4] = v4[CW-1:0];
		row.c[5] = v5[CW-1:0];
		row.known = known;
		row.res.perim = perim[PERIM_W-1:0];
		row.res.area = area[AREA_W-1:0];
		rows.push_back(row);
	endtask

	// Leaves s_tvalid high after acceptance; the next request or the caller drops it.
	task automatic send_triangle(tri_row_t row);
		tri_result_t pred;
		pred = triangle_metrics(row.c);
		if (row.known && pred != row.res)
			$display("%0t: table row disagrees with predictor, using table", $time);
		while (!no_idle && $urandom_range(99) < 28) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= IN_W'({row.c[5], row.c[4], row.c[3], row.c[2], row.c[1], row.c[0]});
		do @(posedge clk); while (!s_tready);
		expected_q.push_back(row.known ? row.res : pred);
	endtask

	function automatic tri_row_t random_row();
		tri_row_t row;
		int mode;
		mode = $urandom_range(3);
		for (int i = 0; i < 6; i++) begin
			case (mode)
				0: row.c[i] = CW'($urandom);
				1: row.c[i] = CW'($urandom_range(0, 511) - 256);
				2: row.c[i] = CW'($urandom_range(0, 8191) - 4096);
				default: row.c[i] = (i < 2) ? CW'($urandom) : row.c[i-2] + CW'($urandom_range(0, 15) - 8);
			endcase
		end
		row.known = 0;
		return row;
	endfunction

	// Receiver: random stalls, plus one long hold while the sender keeps offering.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= !rx_hold && (no_idle || $urandom_range(99) >= 28);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_q.size() == 0) begin
				$display("%0t: result expected none actual %h", $time, m_tdata);
				errors++;
			end else begin
				tri_result_t e;
				e = expected_q.pop_front();
				if (m_tdata[PERIM_W-1:0] !== e.perim) begin
					$display("%0t: perimeter expected %0d actual %0d", $time, e.perim,
						m_tdata[PERIM_W-1:0]);
					errors++;
				end
				if (m_tdata[PERIM_W+AREA_W-1:PERIM_W] !== e.area) begin
					$display("%0t: area expected %0d actual %0d", $time, e.area,
						m_tdata[PERIM_W+AREA_W-1:PERIM_W]);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > STALL_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		errors = 0;
		quiet_cycles = 0;
		rx_hold = 0;
		no_idle = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		// All-zero points, unit right triangle, degenerate line, extremes.
		add_row(0, 0, 0, 0, 0, 0, 1, 0, 0);
		add_row(0, 0, 256, 0, 0, 256);
		add_row(0, 0, 768, 0, 0, 1024);
		add_row(0, 0, 256, 256, 512, 512);
		add_row(0, 0, 1, 0, 2, 0);
		add_row(-32768, -32768, 32767, 32767, -32768, 32767);
		add_row(32767, 32767, -32768, -32768, 32767, -32768);
		add_row(-32768, 0, 32767, 0, 0, 32767);
		add_row(-32768, -32768, -32768, -32768, -32768, -32768, 1, 0, 0);
		add_row(32767, 32767, 32767, 32767, 32767, 32767, 1, 0, 0);
		add_row(-1, -1, 0, 0, 1, 1);
		add_row(0, 0, 1, 0, 0, 1);
		add_row(100, -200, -3000, 4000, 12345, -6789);
		add_row(21845, -21846, -21846, 21845, 0, 0);
		add_row(-32768, 32767, 32767, -32768, 0, 1);
		add_row(0, 0, 65535, 0, 0, 65535);
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[i])
			send_triangle(rows[i]);
		s_tvalid <= 1'b0;
		// Sender pauses until the pipeline has drained.
		while (expected_q.size() != 0)
			@(posedge clk);
		for (int n = 0; n < N_RANDOM; n++) begin
			if (n == 200) begin
				rx_hold = 1;
				fork
					begin
						repeat (300) @(posedge clk);
						rx_hold = 0;
					end
				join_none
			end
			no_idle = (n >= 600 && n < 900);
			send_triangle(random_row());
		end
		s_tvalid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule

>>> triangle_perimeter_area_unit.f
design/tpa_pkg.sv
design/tpa_sqrt_cell.sv
design/tpa_sqrt_chain.sv
design/tpa_side_front.sv
design/tpa_heron_prod.sv
design/triangle_perimeter_area_unit.sv
test/triangle_perimeter_area_unit_tb.sv
